// ===== sv/flit_packetizer_injector_top_defines.svh =====
// Assertion macros shared by the checker of the flit injector.
`ifndef FLIT_PACKETIZER_INJECTOR_TOP_DEFINES_SVH
`define FLIT_PACKETIZER_INJECTOR_TOP_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define FPI_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define FPI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fpi_pkg.sv =====
// Types, codes and constants shared by the flit injector modules.
package fpi_pkg;

  // Default message queue depth and the longest packet the injector keeps.
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int MAX_PACKET_FLITS = 64;

  // Depth of the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;

  // Configuration register indexes and reset values.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISCARD_ENABLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISCARD_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_CHECK_ENABLE = 2'd2;
  localparam logic [4:0]             DISCARD_THRESHOLD_RST = 5'd10;

  typedef enum logic {
    REQ_ENQUEUE = 1'b0,
    REQ_TICK    = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    FLIT_HEAD      = 2'd0,
    FLIT_BODY      = 2'd1,
    FLIT_TAIL      = 2'd2,
    FLIT_HEAD_TAIL = 2'd3
  } flit_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // Input transaction payload.
  typedef struct packed {
    req_kind_t   req_type;
    logic        external_msg;
    logic [7:0]  message_packets;
    logic [6:0]  packet_flits;
    logic [9:0]  source_node;
    logic [9:0]  dest_node;
    logic [31:0] gen_time;
    logic [31:0] now_time;
    logic        stop_active;
    logic [15:0] pool_free;
  } req_item_t;

  // Output transaction payload.
  typedef struct packed {
    flit_kind_t  flit_type;
    logic [9:0]  flit_src;
    logic [9:0]  flit_dst;
    logic [6:0]  flit_index;
    logic [7:0]  packet_index;
    logic [6:0]  flit_packet_len;
    logic [31:0] inject_time;
    logic [31:0] flit_gen_time;
    logic [31:0] sent_total;
  } flit_item_t;

  // Message descriptor as kept in the message queue.
  typedef struct packed {
    logic [9:0] dst;
    logic [9:0] src;
    logic [6:0] flits;
    logic [7:0] packets;
  } msg_desc_t;

  typedef struct packed {
    msg_desc_t   desc;
    logic [31:0] stamp;
  } queue_entry_t;

  // Classified command handed from front to back.
  typedef struct packed {
    req_kind_t    kind;
    logic         external_msg;
    queue_entry_t entry;
    logic [31:0]  now_time;
    logic         stop_active;
    logic [15:0]  pool_free;
  } cmd_t;

  // Configuration register group.
  typedef struct packed {
    logic       discard_enable;
    logic [4:0] discard_threshold;
    logic       pool_check_enable;
  } cfg_t;

endpackage

// ===== sv/fpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/fpi_front.sv =====
// Front end: accepts request transactions and turns them into commands.
module fpi_front import fpi_pkg::*; (
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  input  logic      cmdq_full,
  output logic      cmd_push,
  output cmd_t      cmd
);

  logic [7:0] packets_norm;
  logic [6:0] flits_norm;

  // Accept whenever the command queue has room.
  assign req_stall = cmdq_full;
  assign cmd_push  = req_valid && !cmdq_full;

  // Zero counts become one, and long packets are cut to the supported length.
  always_comb begin
    packets_norm = (req.message_packets == 8'd0) ? 8'd1 : req.message_packets;
    if (req.packet_flits == 7'd0) begin
      flits_norm = 7'd1;
    end else if (32'(req.packet_flits) > MAX_PACKET_FLITS) begin
      flits_norm = 7'(MAX_PACKET_FLITS);
    end else begin
      flits_norm = req.packet_flits;
    end
  end

  // Build the command that the back end executes.
  always_comb begin
    cmd.kind                = req.req_type;
    cmd.external_msg        = req.external_msg;
    cmd.entry.desc.dst      = req.dest_node;
    cmd.entry.desc.src      = req.source_node;
    cmd.entry.desc.flits    = flits_norm;
    cmd.entry.desc.packets  = packets_norm;
    cmd.entry.stamp         = req.gen_time;
    cmd.now_time            = req.now_time;
    cmd.stop_active         = req.stop_active;
    cmd.pool_free           = req.pool_free;
  end

endmodule

// ===== sv/fpi_cmd_fifo.sv =====
// Short command queue that decouples the front end from the back end.
module fpi_cmd_fifo import fpi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entries [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(CMDQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage of queued commands.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/fpi_back.sv =====
// Back end: message queue, flit sequencing and the output register.
module fpi_back import fpi_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       flit_valid,
  input  logic       flit_stall,
  output flit_item_t flit
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int EW   = $bits(queue_entry_t);

  back_state_t   state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [6:0]    cur_flit, cur_flit_next;
  logic [7:0]    cur_packet, cur_packet_next;
  logic [31:0]   held_inject_time, held_inject_time_next;
  logic [31:0]   flits_sent_count, flits_sent_count_next;
  logic [31:0]   tick_now;
  logic [15:0]   tick_pool;

  logic          ram_wr_en;
  logic          ram_rd_en;
  logic [EW-1:0] ram_rd_data;
  queue_entry_t  head_entry;

  logic          start_read;
  logic          enq_drop;
  logic          out_free;
  logic [14:0]   pool_need;
  logic          pool_short;
  logic          emit;
  flit_item_t    flit_next;

  // Message descriptors and stamps.
  fpi_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_msg_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail),
    .wr_data (cmd.entry),
    .rd_en   (ram_rd_en),
    .rd_addr (head),
    .rd_data (ram_rd_data)
  );

  assign head_entry = queue_entry_t'(ram_rd_data);

  // Command classification against the queue state.
  assign start_read = (cmd.kind == REQ_TICK) && !cmd.stop_active && (count != '0);
  assign enq_drop   = (!cmd.external_msg && cfg.discard_enable &&
                       (CMPW'(count) > CMPW'(cfg.discard_threshold))) ||
                      (count == CW'(QUEUE_DEPTH));

  // With the pool check enabled, the whole message must fit in the downstream pool at a packet's first flit.
  assign pool_need  = {7'd0, head_entry.desc.packets} * {8'd0, head_entry.desc.flits};
  assign pool_short = (cur_flit == 7'd1) && cfg.pool_check_enable &&
                      (tick_pool < {1'b0, pool_need});

  // The output register can take a new flit this cycle.
  assign out_free = !flit_valid || !flit_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && start_read) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    cmd_pop               = 1'b0;
    ram_wr_en             = 1'b0;
    ram_rd_en             = 1'b0;
    emit                  = 1'b0;
    head_next             = head;
    tail_next             = tail;
    count_next            = count;
    cur_flit_next         = cur_flit;
    cur_packet_next       = cur_packet;
    held_inject_time_next = held_inject_time;
    flits_sent_count_next = flits_sent_count;
    flit_next             = flit;

    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == REQ_ENQUEUE && !enq_drop) begin
            ram_wr_en  = 1'b1;
            tail_next  = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            count_next = count + 1'b1;
          end
          if (start_read) begin
            ram_rd_en = 1'b1;
          end
        end
      end
      BK_EXEC: begin
        if (out_free && !pool_short) begin
          emit = 1'b1;

          // Flit type and injection time.
          if (cur_flit == 7'd1) begin
            held_inject_time_next = (tick_now > head_entry.stamp) ? tick_now
                                                                   : head_entry.stamp;
            flit_next.flit_type   = (head_entry.desc.flits == 7'd1) ? FLIT_HEAD_TAIL
                                                                    : FLIT_HEAD;
          end else if (cur_flit >= head_entry.desc.flits) begin
            flit_next.flit_type = FLIT_TAIL;
          end else begin
            flit_next.flit_type = FLIT_BODY;
          end

          // Advance within the packet, then the message, then the queue.
          if (cur_flit < head_entry.desc.flits) begin
            cur_flit_next = cur_flit + 7'd1;
          end else if (cur_packet < head_entry.desc.packets) begin
            cur_packet_next = cur_packet + 8'd1;
            cur_flit_next   = 7'd1;
          end else begin
            head_next       = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count_next      = count - 1'b1;
            cur_flit_next   = 7'd1;
            cur_packet_next = 8'd1;
          end

          flits_sent_count_next = flits_sent_count + 32'd1;

          flit_next.flit_src        = head_entry.desc.src;
          flit_next.flit_dst        = head_entry.desc.dst;
          flit_next.flit_index      = cur_flit;
          flit_next.packet_index    = cur_packet;
          flit_next.flit_packet_len = head_entry.desc.flits;
          flit_next.inject_time     = held_inject_time_next;
          flit_next.flit_gen_time   = head_entry.stamp;
          flit_next.sent_total      = flits_sent_count_next;
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= BK_IDLE;
      head             <= '0;
      tail             <= '0;
      count            <= '0;
      cur_flit         <= 7'd1;
      cur_packet       <= 8'd1;
      held_inject_time <= '0;
      flits_sent_count <= '0;
      flit_valid       <= 1'b0;
    end else begin
      state            <= state_next;
      head             <= head_next;
      tail             <= tail_next;
      count            <= count_next;
      cur_flit         <= cur_flit_next;
      cur_packet       <= cur_packet_next;
      held_inject_time <= held_inject_time_next;
      flits_sent_count <= flits_sent_count_next;
      if (emit) begin
        flit_valid <= 1'b1;
      end else if (!flit_stall) begin
        flit_valid <= 1'b0;
      end
    end
  end

  // Payload registers: tick operands and the outgoing flit.
  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_valid) begin
      tick_now  <= cmd.now_time;
      tick_pool <= cmd.pool_free;
    end
    if (emit) begin
      flit <= flit_next;
    end
  end

endmodule

// ===== sv/flit_packetizer_injector_top.sv =====
// Top level of the flit injector: configuration registers, front, queue and back.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_item_t
//   flit    | out       | flit_valid/flit_stall | flit_item_t
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// The front accepts one request per cycle while the two-entry command queue has room.
// The back executes an enqueue, a stopped tick or a tick on an empty queue in idle.
// A tick that reads the queue also enters the exec state, because the message RAM
// has a registered read port; it leaves exec once the output register is free,
// whether it sends a flit into that register or is held back by a short pool.
// Reset is synchronous; the message RAM has no clearing pass and needs none.
// A stalled output flit holds, and the back waits on it before the next flit.
module flit_packetizer_injector_top import fpi_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_item_t              req,
  output logic                   flit_valid,
  input  logic                   flit_stall,
  output flit_item_t             flit,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  cfg_t cfg;
  logic cmdq_full;
  logic cmd_push;
  cmd_t push_cmd;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t head_cmd;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.discard_enable    <= 1'b0;
      cfg.discard_threshold <= DISCARD_THRESHOLD_RST;
      cfg.pool_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DISCARD_ENABLE:    cfg.discard_enable    <= cfg_data[0];
        CFG_DISCARD_THRESHOLD: cfg.discard_threshold <= cfg_data[4:0];
        CFG_POOL_CHECK_ENABLE: cfg.pool_check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fpi_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmdq_full (cmdq_full),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd)
  );

  fpi_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (push_cmd),
    .full       (cmdq_full),
    .pop        (cmd_pop),
    .head_valid (cmd_valid),
    .head_cmd   (head_cmd)
  );

  fpi_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (head_cmd),
    .cmd_pop    (cmd_pop),
    .flit_valid (flit_valid),
    .flit_stall (flit_stall),
    .flit       (flit)
  );

endmodule

// ===== sv/fpi_checker.sv =====
// Port-level checks of the flit injector output, bound to the top level.
`include "flit_packetizer_injector_top_defines.svh"

module fpi_checker import fpi_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       flit_valid,
  input logic       flit_stall,
  input flit_item_t flit
);

  // A stalled flit stays offered and unchanged.
  `FPI_ASSERT_NEXT(a_flit_hold, flit_valid && flit_stall, flit_valid && $stable(flit), "stalled flit changed")

  // Only the first flit of a packet is a head or head-tail flit.
  `FPI_ASSERT_NOW(a_head_first, flit_valid, ((flit.flit_type == FLIT_HEAD) || (flit.flit_type == FLIT_HEAD_TAIL)) == (flit.flit_index == 7'd1), "head type and first index disagree")

  // A head-tail flit belongs to a single-flit packet.
  `FPI_ASSERT_NOW(a_single_flit, flit_valid, (flit.flit_type == FLIT_HEAD_TAIL) == (flit.flit_packet_len == 7'd1), "head-tail type and packet length disagree")

  // A tail flit is the last flit of a longer packet.
  `FPI_ASSERT_NOW(a_tail_last, flit_valid, (flit.flit_type == FLIT_TAIL) == ((flit.flit_index == flit.flit_packet_len) && (flit.flit_index != 7'd1)), "tail type and last index disagree")

endmodule

bind flit_packetizer_injector_top fpi_checker u_fpi_checker (
  .clk        (clk),
  .rst        (rst),
  .flit_valid (flit_valid),
  .flit_stall (flit_stall),
  .flit       (flit)
);
